[design/irm_pkg.sv]
// shared types and constants of the icmp reply matcher
package irm_pkg;

    // longest packet that is still classified, in bytes
    localparam int MAX_PACKET_BYTES = 65535;
    // entries in the queue between the parser and the classifier
    localparam int SUMMARY_DEPTH = 4;

    localparam logic [3:0] IP_VERSION         = 4'd4;
    localparam logic [5:0] MIN_IP_HEADER      = 6'd20;
    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    localparam logic [1:0] OUTCOME_MALFORMED  = 2'd0;
    localparam logic [1:0] OUTCOME_NO_MATCH   = 2'd1;
    localparam logic [1:0] OUTCOME_ECHO_MATCH = 2'd2;
    localparam logic [1:0] OUTCOME_TE_MATCH   = 2'd3;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_IDENTIFIER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_SEQUENCE   = 8'd1;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
    } packet_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [15:0] icmp_checksum;
        logic [7:0]  hop_limit;
        logic [31:0] source_address;
        logic [15:0] data_length;
    } result_t;

    // fields captured from one packet, handed from parser to classifier
    typedef struct packed {
        logic [15:0] last_offset;
        logic        version_ok;
        logic [5:0]  outer_hlen;
        logic [7:0]  ttl;
        logic [31:0] source;
        logic [15:0] type_code;
        logic [15:0] checksum;
        logic [31:0] outer_id_seq;
        logic [5:0]  inner_hlen;
        logic [31:0] inner_id_seq;
    } summary_t;

endpackage

[design/icmp_reply_matcher_unit.sv]
// top level of the icmp reply matcher
//
// input channel: one ipv4 packet byte per item on packet, with end_of_packet
//   set on the final byte; an item is taken when push is high and full is low
// result channel: one item per packet, the oldest on result while empty is low,
//   taken when pop is high; outcome, outer icmp type/code/checksum, ttl,
//   ip source address and data length
// configuration: cfg_valid/cfg_ready write match_identifier (index 0) and
//   match_sequence (index 1); cfg_ready is always high, other indexes are ignored
// throughput: one byte per cycle unless full; the parser keeps only an offset
//   counter and captured fields, and packets of any length can follow each other
//   directly; result path: the summary enters the queue when the final byte is
//   taken and moves into the result register once that register is empty or popped
// stall: a held result keeps its place; up to four finished packets wait in the
//   summary queue, and full rises only once that queue is full
// reset: the byte counter, captured fields, queue and result valid flag clear,
//   both match registers return to zero
module icmp_reply_matcher_unit
    import irm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  packet_t                packet,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic     accept;
    logic     summary_push;
    summary_t summary_in;
    summary_t summary_out;
    logic     summary_valid;
    logic     summary_take;

    // a byte is taken whenever the queue has room for a possible final byte
    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    irm_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .packet       (packet),
        .summary_push (summary_push),
        .summary      (summary_in)
    );

    irm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (summary_push),
        .wr_data   (summary_in),
        .rd_en     (summary_take),
        .rd_data   (summary_out),
        .full      (full),
        .not_empty (summary_valid)
    );

    irm_classifier u_classifier (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .summary_valid (summary_valid),
        .summary       (summary_out),
        .summary_take  (summary_take),
        .pop           (pop),
        .empty         (empty),
        .result        (result)
    );

endmodule

[design/irm_parser.sv]
// front end: walks the packet bytes and captures header fields
module irm_parser
    import irm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  packet_t  packet,
    output logic     summary_push,
    output summary_t summary
);

    logic [15:0] offset_reg;
    logic [5:0]  hlen_reg;
    logic        ver_reg;
    logic [7:0]  ttl_reg;
    logic [31:0] src_reg;
    logic [15:0] type_code_reg;
    logic [15:0] checksum_reg;
    logic [31:0] oid_reg;
    logic [5:0]  ihlen_reg;
    logic [31:0] iid_reg;

    logic [7:0]  b;
    logic        idx_zero;
    logic [5:0]  hlen_next;
    logic        ver_next;
    logic [7:0]  ttl_next;
    logic [31:0] src_next;
    logic [6:0]  outer_end;
    logic        in_outer;
    logic [2:0]  rel;
    logic [15:0] type_code_next;
    logic [15:0] checksum_next;
    logic [31:0] oid_next;
    logic [5:0]  ihlen_next;
    logic [7:0]  inner_base;
    logic [8:0]  inner_lo;
    logic [8:0]  inner_hi;
    logic        in_inner;
    logic [31:0] iid_next;
    logic [15:0] offset_next;

    always_comb
    begin
        b         = packet.packet_byte;
        idx_zero  = (offset_reg == 16'd0);
        // header length is usable on the very byte that carries it
        hlen_next = idx_zero ? {b[3:0], 2'b00} : hlen_reg;
        ver_next  = idx_zero ? (b[7:4] == IP_VERSION) : ver_reg;
        ttl_next  = (offset_reg == 16'd8) ? b : ttl_reg;
        src_next  = (offset_reg >= 16'd12 && offset_reg <= 16'd15) ?
                    {src_reg[23:0], b} : src_reg;

        outer_end = {1'b0, hlen_next} + 7'd8;
        in_outer  = (offset_reg >= {10'd0, hlen_next}) &&
                    (offset_reg < {9'd0, outer_end});
        rel       = offset_reg[2:0] - hlen_next[2:0];

        type_code_next = type_code_reg;
        checksum_next  = checksum_reg;
        oid_next       = oid_reg;
        if (in_outer)
        begin
            priority if (rel[2:1] == 2'b00)
                type_code_next = {type_code_reg[7:0], b};
            else if (rel[2] == 1'b0)
                checksum_next = {checksum_reg[7:0], b};
            else
                oid_next = {oid_reg[23:0], b};
        end

        // first byte of the quoted ip header
        ihlen_next = (offset_reg == {9'd0, outer_end}) ? {b[3:0], 2'b00} : ihlen_reg;

        inner_base = {2'b00, hlen_next} + 8'd8 + {2'b00, ihlen_reg};
        inner_lo   = {1'b0, inner_base} + 9'd4;
        inner_hi   = {1'b0, inner_base} + 9'd8;
        in_inner   = (offset_reg >= {7'd0, inner_lo}) && (offset_reg < {7'd0, inner_hi});
        iid_next   = in_inner ? {iid_reg[23:0], b} : iid_reg;

        // counter sticks at all ones so that huge packets stay malformed
        offset_next = (offset_reg == 16'hFFFF) ? offset_reg : offset_reg + 16'd1;

        summary_push = accept && packet.end_of_packet;
        summary.last_offset  = offset_reg;
        summary.version_ok   = ver_next;
        summary.outer_hlen   = hlen_next;
        summary.ttl          = ttl_next;
        summary.source       = src_next;
        summary.type_code    = type_code_next;
        summary.checksum     = checksum_next;
        summary.outer_id_seq = oid_next;
        summary.inner_hlen   = ihlen_next;
        summary.inner_id_seq = iid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            hlen_reg      <= '0;
            ver_reg       <= 1'b0;
            ttl_reg       <= '0;
            src_reg       <= '0;
            type_code_reg <= '0;
            checksum_reg  <= '0;
            oid_reg       <= '0;
            ihlen_reg     <= '0;
            iid_reg       <= '0;
        end
        else if (accept)
        begin
            if (packet.end_of_packet)
            begin
                offset_reg    <= '0;
                hlen_reg      <= '0;
                ver_reg       <= 1'b0;
                ttl_reg       <= '0;
                src_reg       <= '0;
                type_code_reg <= '0;
                checksum_reg  <= '0;
                oid_reg       <= '0;
                ihlen_reg     <= '0;
                iid_reg       <= '0;
            end
            else
            begin
                offset_reg    <= offset_next;
                hlen_reg      <= hlen_next;
                ver_reg       <= ver_next;
                ttl_reg       <= ttl_next;
                src_reg       <= src_next;
                type_code_reg <= type_code_next;
                checksum_reg  <= checksum_next;
                oid_reg       <= oid_next;
                ihlen_reg     <= ihlen_next;
                iid_reg       <= iid_next;
            end
        end
    end

endmodule

[design/irm_fifo.sv]
// short queue of packet summaries between parser and classifier
module irm_fifo
    import irm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  summary_t wr_data,
    input  logic     rd_en,
    output summary_t rd_data,
    output logic     full,
    output logic     not_empty
);

    localparam int PTR_W = (SUMMARY_DEPTH > 1) ? $clog2(SUMMARY_DEPTH) : 1;
    localparam int CNT_W = $clog2(SUMMARY_DEPTH + 1);

    summary_t           entry_reg [SUMMARY_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;

    always_comb
    begin
        full        = (count_reg == CNT_W'(SUMMARY_DEPTH));
        not_empty   = (count_reg != '0);
        rd_data     = entry_reg[rd_ptr_reg];
        wr_ptr_next = (wr_ptr_reg == PTR_W'(SUMMARY_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(SUMMARY_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_next;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_next;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[design/irm_classifier.sv]
// back end: bounds checks, id and sequence match, result register
module irm_classifier
    import irm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   summary_valid,
    input  summary_t               summary,
    output logic                   summary_take,
    input  logic                   pop,
    output logic                   empty,
    output result_t                result
);

    logic [15:0] match_id_reg;
    logic [15:0] match_seq_reg;
    logic        valid_reg;
    result_t     result_reg;

    logic [16:0] pkt_len;
    logic        malformed;
    logic [15:0] icmp_bytes;
    logic [31:0] want;
    logic [7:0]  outer_type;
    logic        te_bounds_ok;
    result_t     result_next;

    always_comb
    begin
        pkt_len   = {1'b0, summary.last_offset} + 17'd1;
        malformed = ({1'b0, summary.last_offset} >= 17'(MAX_PACKET_BYTES)) ||
                    (pkt_len < 17'd20) ||
                    !summary.version_ok ||
                    (summary.outer_hlen < MIN_IP_HEADER) ||
                    (pkt_len < {11'd0, summary.outer_hlen} + 17'd8);
        icmp_bytes = pkt_len[15:0] - {10'd0, summary.outer_hlen};
        want       = {match_id_reg, match_seq_reg};
        outer_type = summary.type_code[15:8];
        // quoted header must fit with its icmp header behind it
        te_bounds_ok = (icmp_bytes >= 16'd36) &&
                       (summary.inner_hlen >= MIN_IP_HEADER) &&
                       ({10'd0, summary.inner_hlen} + 16'd16 <= icmp_bytes);

        result_next.outcome        = OUTCOME_NO_MATCH;
        result_next.icmp_type      = outer_type;
        result_next.icmp_code      = summary.type_code[7:0];
        result_next.icmp_checksum  = summary.checksum;
        result_next.hop_limit      = summary.ttl;
        result_next.source_address = summary.source;
        result_next.data_length    = '0;
        if (malformed)
            result_next = '0;
        else if (outer_type == TYPE_ECHO_REPLY)
        begin
            if (summary.outer_id_seq == want)
            begin
                result_next.outcome     = OUTCOME_ECHO_MATCH;
                result_next.data_length = icmp_bytes - 16'd8;
            end
        end
        else if (outer_type == TYPE_TIME_EXCEEDED)
        begin
            if (te_bounds_ok && summary.inner_id_seq == want)
            begin
                result_next.outcome     = OUTCOME_TE_MATCH;
                result_next.data_length = icmp_bytes;
            end
        end

        summary_take = summary_valid && (!valid_reg || pop);
        empty        = !valid_reg;
        result       = result_reg;
    end

    always_ff @(posedge clk)
    begin
        if (summary_take)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_id_reg  <= '0;
            match_seq_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MATCH_IDENTIFIER: match_id_reg  <= cfg_data;
                    CFG_MATCH_SEQUENCE:   match_seq_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (summary_take)
                valid_reg <= 1'b1;
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

endmodule

[design/irm_checker.sv]
// port-level checks of the icmp reply matcher, bound to the top level
module irm_checker
    import irm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // nothing to deliver right after a reset edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    // malformed packets report all fields zero
    a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.outcome == OUTCOME_MALFORMED) |->
        (result.icmp_type == 8'd0 && result.icmp_code == 8'd0 &&
         result.icmp_checksum == 16'd0 && result.hop_limit == 8'd0 &&
         result.source_address == 32'd0 && result.data_length == 16'd0))
        else $error("malformed result with nonzero fields");

    a_no_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.outcome == OUTCOME_NO_MATCH) |-> result.data_length == 16'd0)
        else $error("no-match result with data length");

    // a match outcome agrees with the reported icmp type
    a_match_type: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |->
        ((result.outcome != OUTCOME_ECHO_MATCH || result.icmp_type == TYPE_ECHO_REPLY) &&
         (result.outcome != OUTCOME_TE_MATCH || result.icmp_type == TYPE_TIME_EXCEEDED)))
        else $error("match outcome disagrees with icmp type");

endmodule

bind icmp_reply_matcher_unit irm_checker u_irm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

[tb/icmp_reply_matcher_unit_tb.sv]
// self-checking testbench for the icmp reply matcher: directed and random packets vs a predictor
`timescale 1ns / 1ps

module icmp_reply_matcher_unit_tb;
    import irm_pkg::*;

    localparam int CLK_HALF_NS       = 6;
    localparam int RESET_CYCLES      = 6;
    // allowance for the result path after the final byte; a little slack on top
    localparam int RESULT_LATENCY    = 1;
    localparam int CYCLE_LIMIT       = 1000000;
    localparam int RANDOM_BYTES      = 300;
    localparam int ICMP_HEADER_BYTES = 8;
    // shortest time exceeded body that can hold a quoted header and its icmp header
    localparam int MIN_TE_ICMP_BYTES = 36;

    localparam logic [7:0] TYPE_ECHO_REQUEST     = 8'd8;
    localparam logic [7:0] TYPE_DEST_UNREACHABLE = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'd2;

    typedef enum logic { RX_ALWAYS, RX_PATTERN } rx_mode_t;

    // dut connections, inputs known from time zero
    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    push      = 1'b0;
    logic    full;
    packet_t packet    = '0;
    logic    empty;
    logic    pop       = 1'b0;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor copy of the match registers and of the per-packet capture
    logic [15:0] want_id        = '0;
    logic [15:0] want_seq       = '0;
    logic [15:0] pos            = '0;
    logic [5:0]  hdr_len        = '0;
    logic        ver_good       = 1'b0;
    logic [7:0]  ttl_seen       = '0;
    logic [31:0] src_seen       = '0;
    logic [15:0] type_code_seen = '0;
    logic [15:0] cks_seen       = '0;
    logic [31:0] echo_tag       = '0;
    logic [5:0]  inner_len      = '0;
    logic [31:0] inner_tag      = '0;

    // verdicts predicted for packets whose final byte went in, oldest first
    result_t pending_verdicts[$];
    result_t expected_verdict;

    // packet under construction, one entry per byte in wire order
    logic [7:0] pkt_buf[$];

    // id and sequence the stimulus aims at for matching packets
    logic [15:0] target_id  = '0;
    logic [15:0] target_seq = '0;

    // sender pacing
    logic tx_gaps    = 1'b0;
    int   burst_left = 0;

    // receiver pacing: hold_request is raised by a test, hold_left is counted here only
    rx_mode_t    rx_mode      = RX_ALWAYS;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          rx_tick      = 0;
    logic [15:0] rx_pattern   = 16'hFFFF;

    // bookkeeping
    int error_count       = 0;
    int cycle_count       = 0;
    int bytes_sent        = 0;
    int packets_sent      = 0;
    int config_writes     = 0;
    int full_stall_cycles = 0;
    int outcome_count[4]  = '{0, 0, 0, 0};

    icmp_reply_matcher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .packet    (packet),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // back to the state between packets
    function automatic void clear_capture();
        pos            = '0;
        hdr_len        = '0;
        ver_good       = 1'b0;
        ttl_seen       = '0;
        src_seen       = '0;
        type_code_seen = '0;
        cks_seen       = '0;
        echo_tag       = '0;
        inner_len      = '0;
        inner_tag      = '0;
    endfunction

    // take one accepted byte; on the final byte queue the verdict for the packet
    function automatic void classify_byte(logic [7:0] b, logic last);
        int      idx;
        int      h;
        int      ih;
        int      base;
        int      len;
        int      icmp_bytes;
        result_t r;
        idx = pos;
        // version and ihl come from the very first byte
        if (idx == 0)
        begin
            ver_good = (b[7:4] == IP_VERSION);
            hdr_len  = {b[3:0], 2'b00};
        end
        if (idx == 8)
            ttl_seen = b;
        if (idx >= 12 && idx <= 15)
            src_seen = {src_seen[23:0], b};
        // outer icmp header sits right after the ip header, wherever ihl puts it
        h = hdr_len;
        if (idx >= h && idx < h + ICMP_HEADER_BYTES)
        begin
            if (idx - h < 2)
                type_code_seen = {type_code_seen[7:0], b};
            else if (idx - h < 4)
                cks_seen = {cks_seen[7:0], b};
            else
                echo_tag = {echo_tag[23:0], b};
        end
        // quoted ip header of a time exceeded message, then its icmp id and sequence
        if (idx == h + ICMP_HEADER_BYTES)
            inner_len = {b[3:0], 2'b00};
        ih   = inner_len;
        base = h + ICMP_HEADER_BYTES + ih;
        if (idx >= base + 4 && idx < base + 8)
            inner_tag = {inner_tag[23:0], b};
        if (!last)
        begin
            // the counter sticks at its top so that overlong packets stay overlong
            pos = (idx < 65535) ? 16'(idx + 1) : 16'hFFFF;
            return;
        end
        len = idx + 1;
        r   = '0;
        if (!(len > MAX_PACKET_BYTES || len < MIN_IP_HEADER || !ver_good ||
              h < MIN_IP_HEADER || h > len || len - h < ICMP_HEADER_BYTES))
        begin
            icmp_bytes = len - h;
            r.outcome = OUTCOME_NO_MATCH;
            if (type_code_seen[15:8] == TYPE_ECHO_REPLY)
            begin
                if (echo_tag == {want_id, want_seq})
                begin
                    r.outcome     = OUTCOME_ECHO_MATCH;
                    r.data_length = 16'(icmp_bytes - ICMP_HEADER_BYTES);
                end
            end
            else if (type_code_seen[15:8] == TYPE_TIME_EXCEEDED)
            begin
                if (icmp_bytes >= MIN_TE_ICMP_BYTES && ih >= MIN_IP_HEADER &&
                    ih <= icmp_bytes - ICMP_HEADER_BYTES &&
                    ICMP_HEADER_BYTES + ih + ICMP_HEADER_BYTES <= icmp_bytes &&
                    inner_tag == {want_id, want_seq})
                begin
                    r.outcome     = OUTCOME_TE_MATCH;
                    r.data_length = 16'(icmp_bytes);
                end
            end
            r.icmp_type      = type_code_seen[15:8];
            r.icmp_code      = type_code_seen[7:0];
            r.icmp_checksum  = cks_seen;
            r.hop_limit      = ttl_seen;
            r.source_address = src_seen;
        end
        pending_verdicts.insert(pending_verdicts.size(), r);
        clear_capture();
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one byte at the falling edge and hold it until the block takes it
    task automatic send_item(logic [7:0] b, logic last);
        int gap;
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        @(negedge clk);
        push   <= 1'b1;
        packet <= {b, last};
        do
            @(posedge clk);
        while (full);
        classify_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_buf.size(); i++)
            send_item(pkt_buf[i], i == pkt_buf.size() - 1);
        packets_sent++;
    endtask

    // stop offering and wait for every predicted verdict to come out
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 2) @(negedge clk);
    endtask

    // match registers only change with the block idle between packets
    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_MATCH_IDENTIFIER: want_id  = data;
            CFG_MATCH_SEQUENCE:   want_seq = data;
            default: ;
        endcase
        config_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_match(logic [15:0] id, logic [15:0] seq);
        write_register(CFG_MATCH_IDENTIFIER, id);
        write_register(CFG_MATCH_SEQUENCE, seq);
        target_id  = id;
        target_seq = seq;
    endtask

    // ------------------------------------------------------------------
    // packet construction
    // ------------------------------------------------------------------

    function automatic void append_byte(logic [7:0] v);
        pkt_buf.insert(pkt_buf.size(), v);
    endfunction

    task automatic add_random_bytes(int n);
        repeat (n) append_byte(8'($urandom));
    endtask

    // ip header with random contents; short ihl values still get 20 bytes
    task automatic start_ip_header(logic [3:0] version, logic [3:0] ihl);
        int hlen;
        hlen = (ihl < 5) ? 20 : 4 * int'(ihl);
        pkt_buf.delete();
        append_byte({version, ihl});
        add_random_bytes(hlen - 1);
    endtask

    task automatic add_icmp_header(logic [7:0] kind, logic [7:0] code, logic [15:0] cks,
                                   logic [15:0] id, logic [15:0] seq);
        append_byte(kind);
        append_byte(code);
        append_byte(cks[15:8]);
        append_byte(cks[7:0]);
        append_byte(id[15:8]);
        append_byte(id[7:0]);
        append_byte(seq[15:8]);
        append_byte(seq[7:0]);
    endtask

    task automatic truncate(int n);
        while (pkt_buf.size() > n)
            void'(pkt_buf.pop_back());
    endtask

    task automatic set_ttl_source(logic [7:0] ttl, logic [31:0] src);
        pkt_buf[8] = ttl;
        for (int i = 0; i < 4; i++)
            pkt_buf[12 + i] = src[31 - 8 * i -: 8];
    endtask

    task automatic make_echo(logic [3:0] ihl, logic [7:0] code, logic [15:0] id,
                             logic [15:0] seq, int payload);
        start_ip_header(IP_VERSION, ihl);
        add_icmp_header(TYPE_ECHO_REPLY, code, 16'($urandom), id, seq);
        add_random_bytes(payload);
    endtask

    // time exceeded quoting an echo request that carries id and seq
    task automatic make_time_exceeded(logic [3:0] ihl, logic [3:0] inner_ihl, logic [15:0] id,
                                      logic [15:0] seq, int extra);
        int qlen;
        qlen = (inner_ihl < 5) ? 20 : 4 * int'(inner_ihl);
        start_ip_header(IP_VERSION, ihl);
        add_icmp_header(TYPE_TIME_EXCEEDED, 8'($urandom_range(0, 1)), 16'($urandom),
                        16'($urandom), 16'($urandom));
        append_byte({IP_VERSION, inner_ihl});
        add_random_bytes(qlen - 1);
        add_icmp_header(TYPE_ECHO_REQUEST, 8'd0, 16'($urandom), id, seq);
        add_random_bytes(extra);
    endtask

    function automatic logic [15:0] flip_bit();
        return 16'(1 << $urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] pick_code();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
    endfunction

    // ------------------------------------------------------------------
    // receiver and result checker
    // ------------------------------------------------------------------

    // pop stays high or follows a rotating mask, and stays low through a requested hold
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (rx_mode == RX_ALWAYS)
            pop <= 1'b1;
        else
        begin
            pop <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            rx_tick++;
            // new mask now and then; a quarter of them never stall
            if (rx_tick % 40 == 0)
                rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && push && full)
            full_stall_cycles++;
        if (rst_n && pop && !empty)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result with no packet behind it: outcome %0d", result.outcome);
                error_count++;
            end
            else
            begin
                expected_verdict = pending_verdicts.pop_front();
                check_field("outcome", expected_verdict.outcome, result.outcome);
                check_field("icmp_type", expected_verdict.icmp_type, result.icmp_type);
                check_field("icmp_code", expected_verdict.icmp_code, result.icmp_code);
                check_field("icmp_checksum", expected_verdict.icmp_checksum,
                            result.icmp_checksum);
                check_field("hop_limit", expected_verdict.hop_limit, result.hop_limit);
                check_field("source_address", expected_verdict.source_address,
                            result.source_address);
                check_field("data_length", expected_verdict.data_length, result.data_length);
            end
            outcome_count[result.outcome]++;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // match registers come out of reset as zero
    task automatic test_reset_values();
        make_echo(4'd5, 8'd0, 16'h0000, 16'h0000, 4);
        send_packet();
        make_echo(4'd5, 8'd0, 16'h0000, 16'h0001, 4);
        send_packet();
        drain();
    endtask

    task automatic test_config_writes();
        set_match(16'hFFFF, 16'hFFFF);
        make_echo(4'd5, 8'd0, 16'hFFFF, 16'hFFFF, 2);
        send_packet();
        make_echo(4'd5, 8'd0, 16'h0000, 16'h0000, 2);
        send_packet();
        // a write to an index with no register behind it changes nothing
        write_register(CFG_UNUSED_INDEX, 16'h1234);
        make_echo(4'd5, 8'd0, 16'hFFFF, 16'hFFFF, 2);
        send_packet();
        set_match(16'h0000, 16'hFFFF);
        make_echo(4'd5, 8'd0, 16'h0000, 16'hFFFF, 2);
        send_packet();
        drain();
    endtask

    task automatic test_malformed_packets();
        set_match(16'hA5C3, 16'h5A3C);
        // a lone final byte
        pkt_buf.delete();
        append_byte(8'h45);
        send_packet();
        // one byte short of a minimal ip header
        make_echo(4'd5, 8'd0, target_id, target_seq, 0);
        truncate(19);
        send_packet();
        // wrong version
        start_ip_header(4'd6, 4'd5);
        add_icmp_header(TYPE_ECHO_REPLY, 8'd0, 16'h1111, target_id, target_seq);
        send_packet();
        // ihl below five words
        start_ip_header(IP_VERSION, 4'd4);
        add_icmp_header(TYPE_ECHO_REPLY, 8'd0, 16'h2222, target_id, target_seq);
        send_packet();
        // header length past the end of the packet
        start_ip_header(IP_VERSION, 4'd15);
        truncate(40);
        send_packet();
        // icmp header one byte short, then no icmp bytes at all
        make_echo(4'd5, 8'd0, target_id, target_seq, 0);
        truncate(27);
        send_packet();
        start_ip_header(IP_VERSION, 4'd5);
        send_packet();
        drain();
    endtask

    task automatic test_echo_replies();
        make_echo(4'd5, 8'd0, target_id, target_seq, 0);
        send_packet();
        make_echo(4'd15, 8'd0, target_id, target_seq, 10);
        send_packet();
        make_echo(4'd5, 8'd0, target_id ^ 16'h8000, target_seq, 6);
        send_packet();
        make_echo(4'd5, 8'd0, target_id, target_seq ^ 16'h0001, 6);
        send_packet();
        make_echo(4'd6, 8'hFF, target_id, target_seq, 3);
        send_packet();
        drain();
    endtask

    task automatic test_time_exceeded();
        // smallest body that still matches: exactly 36 icmp bytes
        make_time_exceeded(4'd5, 4'd5, target_id, target_seq, 0);
        send_packet();
        make_time_exceeded(4'd7, 4'd15, target_id, target_seq, 20);
        send_packet();
        // icmp body one byte too short
        make_time_exceeded(4'd5, 4'd5, target_id, target_seq, 0);
        truncate(55);
        send_packet();
        // quoted ihl below five words
        make_time_exceeded(4'd5, 4'd4, target_id, target_seq, 4);
        send_packet();
        // quoted header longer than what follows the outer icmp header
        make_time_exceeded(4'd5, 4'd15, target_id, target_seq, 0);
        truncate(68);
        send_packet();
        // quoted icmp header cut short
        make_time_exceeded(4'd5, 4'd6, target_id, target_seq, 0);
        truncate(58);
        send_packet();
        make_time_exceeded(4'd5, 4'd5, target_id, target_seq ^ 16'h0100, 2);
        send_packet();
        drain();
    endtask

    // id and sequence are right but the type is not one that can match
    task automatic test_other_types();
        start_ip_header(IP_VERSION, 4'd5);
        add_icmp_header(TYPE_ECHO_REQUEST, 8'd0, 16'($urandom), target_id, target_seq);
        send_packet();
        start_ip_header(IP_VERSION, 4'd5);
        add_icmp_header(TYPE_DEST_UNREACHABLE, 8'd1, 16'($urandom), target_id, target_seq);
        add_random_bytes(28);
        send_packet();
        start_ip_header(IP_VERSION, 4'd5);
        add_icmp_header(8'hFF, 8'hFF, 16'($urandom), target_id, target_seq);
        send_packet();
        drain();
    endtask

    task automatic test_field_extremes();
        start_ip_header(IP_VERSION, 4'd5);
        add_icmp_header(TYPE_ECHO_REPLY, 8'hFF, 16'hFFFF, target_id, target_seq);
        set_ttl_source(8'hFF, 32'hFFFF_FFFF);
        send_packet();
        start_ip_header(IP_VERSION, 4'd5);
        add_icmp_header(TYPE_ECHO_REPLY, 8'h00, 16'h0000, target_id, target_seq);
        set_ttl_source(8'h00, 32'h0000_0000);
        send_packet();
        drain();
    endtask

    // receiver holds off while short packets keep coming, so full must rise
    task automatic test_input_backpressure();
        tx_gaps      = 1'b0;
        rx_mode      = RX_ALWAYS;
        hold_request = 300;
        repeat (12)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                pkt_buf.delete();
                add_random_bytes($urandom_range(1, 3));
            end
            else
                make_echo(4'd5, 8'd0, target_id, target_seq, 0);
            send_packet();
        end
        // sender pauses until everything is out
        drain();
    endtask

    task automatic send_random_packet();
        int          pick;
        int          sub;
        int          hlen;
        logic [3:0]  ihl;
        logic [3:0]  ver;
        logic [7:0]  kind;
        pick = $urandom_range(0, 99);
        ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        hlen = 4 * int'(ihl);
        if (pick < 35)
            make_echo(ihl, pick_code(), target_id, target_seq, $urandom_range(0, 24));
        else if (pick < 50)
            make_time_exceeded(ihl, 4'($urandom_range(5, 7)), target_id, target_seq,
                               $urandom_range(0, 8));
        else if (pick < 58)
        begin
            if ($urandom_range(0, 1) == 0)
                make_echo(ihl, pick_code(), target_id ^ flip_bit(), target_seq,
                          $urandom_range(0, 16));
            else
                make_echo(ihl, pick_code(), target_id, target_seq ^ flip_bit(),
                          $urandom_range(0, 16));
        end
        else if (pick < 64)
        begin
            if ($urandom_range(0, 1) == 0)
                make_time_exceeded(ihl, 4'd5, target_id ^ flip_bit(), target_seq, 0);
            else
                make_time_exceeded(ihl, 4'd5, target_id, target_seq ^ flip_bit(), 0);
        end
        else if (pick < 70)
        begin
            // quoted header with any ihl, cut at a random point
            make_time_exceeded(ihl, 4'($urandom_range(0, 15)), target_id, target_seq, 0);
            truncate(hlen + ICMP_HEADER_BYTES + $urandom_range(0, 60));
        end
        else if (pick < 78)
        begin
            kind = 8'($urandom_range(1, 255));
            if (kind == TYPE_TIME_EXCEEDED)
                kind = TYPE_ECHO_REQUEST;
            start_ip_header(IP_VERSION, ihl);
            add_icmp_header(kind, pick_code(), 16'($urandom), target_id, target_seq);
            add_random_bytes($urandom_range(0, 16));
        end
        else if (pick < 90)
        begin
            sub = $urandom_range(0, 3);
            case (sub)
                0:
                begin
                    make_echo(ihl, 8'd0, target_id, target_seq, 0);
                    truncate($urandom_range(1, hlen + ICMP_HEADER_BYTES - 1));
                end
                1:
                begin
                    ver = 4'($urandom_range(0, 14));
                    if (ver >= IP_VERSION)
                        ver++;
                    start_ip_header(ver, ihl);
                    add_icmp_header(TYPE_ECHO_REPLY, 8'd0, 16'($urandom), target_id, target_seq);
                end
                2:
                begin
                    start_ip_header(IP_VERSION, 4'($urandom_range(0, 4)));
                    add_icmp_header(TYPE_ECHO_REPLY, 8'd0, 16'($urandom), target_id, target_seq);
                    add_random_bytes($urandom_range(0, 8));
                end
                default:
                begin
                    ihl = 4'($urandom_range(6, 15));
                    start_ip_header(IP_VERSION, ihl);
                    truncate($urandom_range(20, 4 * int'(ihl) - 1));
                end
            endcase
        end
        else
        begin
            pkt_buf.delete();
            add_random_bytes($urandom_range(1, 40));
        end
        send_packet();
    endtask

    // phases of random packets, each under its own match setting and pacing
    task automatic test_random_traffic();
        int phase;
        int start_bytes;
        phase       = 0;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            case (phase)
                0:       set_match(16'h0000, 16'h0000);
                1:       set_match(16'hFFFF, 16'hFFFF);
                2:       set_match(16'h0000, 16'hFFFF);
                3:       set_match(16'hFFFF, 16'h0000);
                default: set_match(16'($urandom), 16'($urandom));
            endcase
            // every third phase runs the sender flat out
            tx_gaps    = (phase % 3 != 0);
            burst_left = 0;
            rx_mode    = (phase % 4 == 1) ? RX_ALWAYS : RX_PATTERN;
            repeat (4) send_random_packet();
            phase++;
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // sequence and end of run
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL icmp_reply_matcher_unit");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_gaps = 1'b1;
        rx_mode = RX_PATTERN;
        test_reset_values();
        test_config_writes();
        test_malformed_packets();
        test_echo_replies();
        test_time_exceeded();
        test_other_types();
        test_field_extremes();
        test_input_backpressure();
        test_random_traffic();
        drain();

        $display("covered %0d packets, %0d bytes, %0d register writes, %0d cycles",
                 packets_sent, bytes_sent, config_writes, cycle_count);
        $display("outcomes malformed %0d, no match %0d, echo %0d, time exceeded %0d; full held %0d",
                 outcome_count[OUTCOME_MALFORMED], outcome_count[OUTCOME_NO_MATCH],
                 outcome_count[OUTCOME_ECHO_MATCH], outcome_count[OUTCOME_TE_MATCH],
                 full_stall_cycles);
        if (error_count == 0)
            $display("PASS icmp_reply_matcher_unit");
        else
            $display("FAIL icmp_reply_matcher_unit");
        $finish;
    end

endmodule
